### rtl/core/gci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gci_pkg;

   localparam int CoordW   = 16;
   localparam int DeltaW   = CoordW + 2;
   localparam int LineW    = CoordW + 1;
   localparam int ProdW    = 2 * DeltaW;
   localparam int SumW     = ProdW + 1;
   localparam int D2W      = 2 * DeltaW - 1;
   localparam int Len2W    = 2 * LineW;
   localparam int RadW     = CoordW - 1;
   localparam int R2W      = 2 * RadW;
   localparam int PosW     = 8;
   localparam int QsqW     = 2 * PosW;
   localparam int CmpW     = D2W + QsqW;
   localparam int NumCells = PosW;
   localparam int BitW     = $clog2(PosW);
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;

   localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

   typedef enum logic [2:0] {
      RegMode    = 3'd0,
      RegAnchorX = 3'd1,
      RegAnchorY = 3'd2,
      RegEndX    = 3'd3,
      RegEndY    = 3'd4,
      RegRadius  = 3'd5
   } gci_reg_type;

   typedef struct packed {
      logic                     mode;
      logic signed [CoordW-1:0] anchor_x;
      logic signed [CoordW-1:0] anchor_y;
      logic signed [LineW-1:0]  line_x;
      logic signed [LineW-1:0]  line_y;
      logic [Len2W-1:0]         len2;
      logic [R2W-1:0]           r2;
   } gci_cfg_type;

   typedef struct packed {
      logic              zero;
      logic              sat;
      logic [D2W-1:0]    d2;
      logic [Len2W-1:0]  rem;
      logic [PosW-1:0]   q;
      logic [QsqW-1:0]   qsq;
   } gci_lane_type;

endpackage

`default_nettype wire

### rtl/core/gci_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gci_req_if;
   import gci_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] pixel_x;
   logic signed [CoordW-1:0] pixel_y;
   logic signed [CoordW-1:0] origin_x;
   logic signed [CoordW-1:0] origin_y;

   modport source (output valid, output pixel_x, output pixel_y, output origin_x,
                   output origin_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input origin_x,
                   input origin_y, output ready);
endinterface

`default_nettype wire

### rtl/core/gci_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gci_rsp_if;
   import gci_pkg::*;

   logic            valid;
   logic            ready;
   logic [PosW-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

`default_nettype wire

### rtl/core/gci_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module gci_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gci_pkg::CsrAddrW-1:0]    csr_paddr,
   input  wire logic [gci_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic      [gci_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output gci_pkg::gci_cfg_type                 cfg
);
   import gci_pkg::*;

   logic                     mode_ff;
   logic signed [CoordW-1:0] anchor_x_ff, anchor_y_ff, end_x_ff, end_y_ff;
   logic [RadW-1:0]          radius_ff;
   logic signed [LineW-1:0]  line_x_ff, line_y_ff, line_x_in, line_y_in;
   logic [Len2W-1:0]         sq_x_ff, sq_y_ff, len2_ff;
   logic [R2W-1:0]           r2_ff;
   logic                     wr;
   gci_reg_type              idx;

   assign wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = gci_reg_type'(csr_paddr[CsrAddrW-1:2]);
   assign csr_pready = 1'b1;

   assign line_x_in = LineW'(end_x_ff) - LineW'(anchor_x_ff);
   assign line_y_in = LineW'(end_y_ff) - LineW'(anchor_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         end_x_ff    <= '0;
         end_y_ff    <= '0;
         radius_ff   <= RadW'(1);
         line_x_ff   <= '0;
         line_y_ff   <= '0;
         sq_x_ff     <= '0;
         sq_y_ff     <= '0;
         len2_ff     <= '0;
         r2_ff       <= R2W'(1);
      end else begin
         if (wr) begin
            unique case (idx)
               RegMode:    mode_ff     <= csr_pwdata[0];
               RegAnchorX: anchor_x_ff <= csr_pwdata[CoordW-1:0];
               RegAnchorY: anchor_y_ff <= csr_pwdata[CoordW-1:0];
               RegEndX:    end_x_ff    <= csr_pwdata[CoordW-1:0];
               RegEndY:    end_y_ff    <= csr_pwdata[CoordW-1:0];
               RegRadius:  radius_ff   <= csr_pwdata[RadW-1:0];
               default: ;
            endcase
         end
         // derived terms are registered from the registers above
         line_x_ff <= line_x_in;
         line_y_ff <= line_y_in;
         sq_x_ff   <= $unsigned(Len2W'(line_x_in) * Len2W'(line_x_in));
         sq_y_ff   <= $unsigned(Len2W'(line_y_in) * Len2W'(line_y_in));
         len2_ff   <= sq_x_ff + sq_y_ff;
         r2_ff     <= radius_ff * radius_ff;
      end
   end

   always_comb begin
      unique case (idx)
         RegMode:    csr_prdata = CsrDataW'(mode_ff);
         RegAnchorX: csr_prdata = CsrDataW'(anchor_x_ff);
         RegAnchorY: csr_prdata = CsrDataW'(anchor_y_ff);
         RegEndX:    csr_prdata = CsrDataW'(end_x_ff);
         RegEndY:    csr_prdata = CsrDataW'(end_y_ff);
         RegRadius:  csr_prdata = CsrDataW'(radius_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.mode     = mode_ff;
   assign cfg.anchor_x = anchor_x_ff;
   assign cfg.anchor_y = anchor_y_ff;
   assign cfg.line_x   = line_x_ff;
   assign cfg.line_y   = line_y_ff;
   assign cfg.len2     = len2_ff;
   assign cfg.r2       = r2_ff;

endmodule

`default_nettype wire

### rtl/core/gci_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gci_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gci_pkg::gci_cfg_type  cfg,
   gci_req_if.sink                    req,
   output logic                       out_valid,
   output gci_pkg::gci_lane_type      out_lane,
   input  wire logic                  out_ready
);
   import gci_pkg::*;

   logic                     v0_ff, v1_ff, v2_ff;
   logic                     rdy0, rdy1, rdy2;
   logic signed [DeltaW-1:0] dx_ff, dy_ff, dx_in, dy_in, bx, by;
   logic signed [ProdW-1:0]  px_ff, py_ff;
   logic signed [SumW-1:0]   sum;
   logic [SumW-1:0]          mag;
   gci_lane_type             lane_ff, lane_in;

   assign rdy2      = ~v2_ff | out_ready;
   assign rdy1      = ~v1_ff | rdy2;
   assign rdy0      = ~v0_ff | rdy1;
   assign req.ready = ~reset & rdy0;

   assign dx_in = DeltaW'($signed(req.pixel_x)) - DeltaW'($signed(req.origin_x))
                - DeltaW'($signed(cfg.anchor_x));
   assign dy_in = DeltaW'($signed(req.pixel_y)) - DeltaW'($signed(req.origin_y))
                - DeltaW'($signed(cfg.anchor_y));

   // radial squares the offset, linear projects it on the line
   assign bx = cfg.mode ? dx_ff : DeltaW'($signed(cfg.line_x));
   assign by = cfg.mode ? dy_ff : DeltaW'($signed(cfg.line_y));

   assign sum = SumW'(px_ff) + SumW'(py_ff);
   assign mag = sum[SumW-1] ? $unsigned(-sum) : $unsigned(sum);

   always_comb begin
      lane_in      = '0;
      lane_in.zero = (cfg.len2 == '0);
      lane_in.sat  = (mag >= SumW'(cfg.len2));
      lane_in.d2   = mag[D2W-1:0];
      lane_in.rem  = mag[Len2W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req.valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
      end
      if (rdy0) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (rdy1) begin
         px_ff <= dx_ff * bx;
         py_ff <= dy_ff * by;
      end
      if (rdy2) lane_ff <= lane_in;
   end

   assign out_valid = v2_ff;
   assign out_lane  = lane_ff;

endmodule

`default_nettype wire

### rtl/core/gci_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module gci_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [gci_pkg::BitW-1:0]    bit_sel,
   input  wire logic                        mode,
   input  wire logic [gci_pkg::Len2W-1:0]   len2,
   input  wire logic [gci_pkg::R2W-1:0]     r2,
   input  wire logic                        in_valid,
   input  wire gci_pkg::gci_lane_type       in_lane,
   output logic                             in_ready,
   output logic                             out_valid,
   output gci_pkg::gci_lane_type            out_lane,
   input  wire logic                        out_ready
);
   import gci_pkg::*;

   logic                  valid_ff;
   gci_lane_type          lane_ff, lane_in;
   logic [PosW-1:0]       bitv, q_try;
   logic [QsqW-1:0]       qsq_try;
   logic [QsqW+R2W-1:0]   prod;
   logic                  rad_ok, lin_ok, take;
   logic [Len2W:0]        rem2;

   assign in_ready = ~valid_ff | out_ready;

   assign bitv  = PosW'(1) << bit_sel;
   assign q_try = in_lane.q | bitv;
   // (q + b)^2 = q^2 + (2q + b) * b, b a power of two
   assign qsq_try = in_lane.qsq
                  + ((QsqW'({in_lane.q, 1'b0}) + QsqW'(bitv)) << bit_sel);
   assign prod   = (QsqW+R2W)'(qsq_try) * (QsqW+R2W)'(r2);
   assign rad_ok = CmpW'(prod) <= {in_lane.d2, QsqW'(0)};

   // one restoring division step
   assign rem2   = {in_lane.rem, 1'b0};
   assign lin_ok = rem2 >= (Len2W+1)'(len2);
   assign take   = mode ? rad_ok : lin_ok;

   always_comb begin
      lane_in     = in_lane;
      lane_in.q   = take ? q_try : in_lane.q;
      lane_in.qsq = (mode & rad_ok) ? qsq_try : in_lane.qsq;
      lane_in.rem = lin_ok ? Len2W'(rem2 - (Len2W+1)'(len2)) : Len2W'(rem2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !mode && !lane_ff.sat && !lane_ff.zero |-> lane_ff.rem < len2)
      else $error("remainder not below squared length");

   a_qsq_tracks_q: assert property (@(posedge clock) disable iff (reset)
      valid_ff && mode |-> lane_ff.qsq == QsqW'(lane_ff.q * lane_ff.q))
      else $error("square of partial index out of step");

   a_low_bits_clear: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (lane_ff.q & (bitv - PosW'(1))) == '0)
      else $error("index bit set ahead of its cell");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(lane_ff))
      else $error("stalled cell lost its item");

endmodule

`default_nettype wire

### rtl/core/gradient_coverage_index.sv
`timescale 1ns / 1ps
`default_nettype none

// Gradient index generator: one pixel transfer in, one 8-bit color ramp position out,
// one item per clock sustained while the result side does not stall (three front stages for
// offset, products and sum, a row of 8 cells that each resolve one index bit, and the
// output register). Linear mode divides the projection by the squared line length one
// quotient bit per cell; radial mode finds the largest index whose scaled square fits under
// the squared distance, one bit per cell. Stalls at the result side back up through the
// chain and fill bubbles first. Line length and radius squares are derived from the CSR
// registers: the radius square directly, the squared length from registered squares.
module gradient_coverage_index (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gci_req_if.sink                             req,
   gci_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [gci_pkg::CsrAddrW-1:0]   csr_paddr,
   input  wire logic [gci_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic      [gci_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import gci_pkg::*;

   gci_cfg_type     cfg;
   logic            chain_valid [NumCells+1];
   logic            chain_ready [NumCells+1];
   gci_lane_type    chain_lane  [NumCells+1];
   logic            out_valid_ff;
   logic [PosW-1:0] position_ff, position_in;
   gci_lane_type    last;

   gci_csr u_csr (
      .clock, .reset,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready,
      .cfg
   );

   gci_front u_front (
      .clock, .reset, .cfg, .req,
      .out_valid (chain_valid[0]),
      .out_lane  (chain_lane[0]),
      .out_ready (chain_ready[0])
   );

   for (genvar j = 0; j < NumCells; j++) begin : g_cell
      gci_cell u_cell (
         .clock, .reset,
         .bit_sel   (BitW'(PosW - 1 - j)),
         .mode      (cfg.mode),
         .len2      (cfg.len2),
         .r2        (cfg.r2),
         .in_valid  (chain_valid[j]),
         .in_lane   (chain_lane[j]),
         .in_ready  (chain_ready[j]),
         .out_valid (chain_valid[j+1]),
         .out_lane  (chain_lane[j+1]),
         .out_ready (chain_ready[j+1])
      );
   end

   assign last                  = chain_lane[NumCells];
   assign chain_ready[NumCells] = ~out_valid_ff | rsp.ready;

   always_comb begin
      if (cfg.mode)       position_in = last.q;
      else if (last.zero) position_in = '0;
      else if (last.sat)  position_in = PosMax;
      else                position_in = last.q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (chain_ready[NumCells]) begin
         out_valid_ff <= chain_valid[NumCells];
      end
      if (chain_ready[NumCells]) position_ff <= position_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.position = position_ff;

endmodule

`default_nettype wire
